/* sv/mfc_pkg.sv */
package mfc_pkg;

  localparam int unsigned CountW   = 8;
  localparam int unsigned HdrLen   = 6;
  localparam int unsigned FrameLen = 152;
  localparam int unsigned OutDataW = 24;

  localparam logic [7:0] VersionByte = 8'h11;
  localparam logic [7:0] BcastNode   = 8'hFF;
  localparam logic [7:0] TypeLocate  = 8'h01;
  localparam logic [7:0] TypeLink    = 8'h02;
  localparam logic [7:0] TypeStatus  = 8'h03;

  // Header byte positions within a frame.
  localparam int unsigned HdrVersion = 0;
  localparam int unsigned HdrSource  = 1;
  localparam int unsigned HdrDest    = 2;
  localparam int unsigned HdrCsum    = 3;
  localparam int unsigned HdrType    = 4;
  localparam int unsigned HdrTag     = 5;

  typedef enum logic [2:0] {
    DropNone     = 3'd0,
    DropLength   = 3'd1,
    DropChecksum = 3'd2,
    DropVersion  = 3'd3,
    DropAddress  = 3'd4
  } drop_reason_e;

  typedef enum logic [1:0] {
    KindLocate  = 2'd0,
    KindLink    = 2'd1,
    KindStatus  = 2'd2,
    KindUnknown = 2'd3
  } frame_kind_e;

  // Packed with the first field in the highest bits.
  typedef struct packed {
    logic         pad;
    logic         was_broadcast;
    logic [7:0]   request_tag;
    logic [7:0]   source_node;
    frame_kind_e  frame_kind;
    drop_reason_e drop_reason;
    logic         accepted;
  } verdict_t;

  function automatic frame_kind_e classify(logic [7:0] t);
    frame_kind_e k;
    case (t)
      TypeLocate: k = KindLocate;
      TypeLink:   k = KindLink;
      TypeStatus: k = KindStatus;
      default:    k = KindUnknown;
    endcase
    return k;
  endfunction

endpackage

/* sv/mfc_skid.sv */
module mfc_skid #(
  parameter int unsigned W = mfc_pkg::OutDataW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic         out_vld_q;
  logic         skid_vld_q;
  logic [W-1:0] out_q;
  logic [W-1:0] skid_q;
  logic         in_fire;
  logic         out_free;

  assign ready_o  = !skid_vld_q;
  assign in_fire  = valid_i && ready_o;
  assign out_free = !out_vld_q || ready_i;
  assign valid_o  = out_vld_q;
  assign data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || in_fire;
      skid_vld_q <= 1'b0;
    end else if (in_fire) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : data_i;
    end else if (in_fire) begin
      skid_q <= data_i;
    end
  end

endmodule

/* sv/mesh_frame_checker.sv */
// A verdict item is registered in the output stage when the final byte of a frame is accepted.
// Throughput: one byte per cycle while the output stage has a free entry; a two-entry output stage
// lets bytes keep flowing while one verdict waits to be taken, and input stalls when both are full.
// Reset: asynchronous, active low; clears the byte counter, sum, captured header,
// the output stage, and sets own_node to 0xFF.
module mesh_frame_checker #(
  parameter int unsigned FRAME_LEN = mfc_pkg::FrameLen
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         own_node_we_i,
  input  logic [7:0]                   own_node_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: [7:0] data_byte
  input  logic [7:0]                   s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: [0] accepted, [3:1] drop_reason, [5:4] frame_kind, [13:6] source_node,
  // [21:14] request_tag, [22] was_broadcast, [23] zero
  output logic [mfc_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CW = mfc_pkg::CountW;
  localparam logic [CW-1:0] LenC = CW'(FRAME_LEN);
  localparam logic [CW-1:0] SatC = CW'(FRAME_LEN + 1);

  logic [7:0]    own_node_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    hdr_q [mfc_pkg::HdrLen];
  logic [7:0]    hdr_d [mfc_pkg::HdrLen];
  logic          in_fire;
  logic          res_valid;
  mfc_pkg::verdict_t verdict;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign res_valid = in_fire && s_axis_tlast;

  // State as it stands once the current byte is counted in.
  always_comb begin
    for (int k = 0; k < mfc_pkg::HdrLen; k++) begin
      hdr_d[k] = (cnt_q == CW'(k)) ? s_axis_tdata : hdr_q[k];
    end
    sum_d = (cnt_q == CW'(mfc_pkg::HdrCsum)) ? sum_q : sum_q + s_axis_tdata;
    cnt_d = (cnt_q < SatC) ? cnt_q + 1'b1 : cnt_q;
  end

  always_comb begin
    verdict = '0;
    if (cnt_d != LenC) begin
      verdict.drop_reason = mfc_pkg::DropLength;
    end else if (sum_d != hdr_d[mfc_pkg::HdrCsum]) begin
      verdict.drop_reason = mfc_pkg::DropChecksum;
    end else if (hdr_d[mfc_pkg::HdrVersion] != mfc_pkg::VersionByte) begin
      verdict.drop_reason = mfc_pkg::DropVersion;
    end else if (hdr_d[mfc_pkg::HdrDest] != mfc_pkg::BcastNode &&
                 hdr_d[mfc_pkg::HdrDest] != own_node_q) begin
      verdict.drop_reason = mfc_pkg::DropAddress;
    end else begin
      verdict.drop_reason   = mfc_pkg::DropNone;
      verdict.accepted      = 1'b1;
      verdict.frame_kind    = mfc_pkg::classify(hdr_d[mfc_pkg::HdrType]);
      verdict.source_node   = hdr_d[mfc_pkg::HdrSource];
      verdict.request_tag   = hdr_d[mfc_pkg::HdrTag];
      verdict.was_broadcast = (hdr_d[mfc_pkg::HdrDest] == mfc_pkg::BcastNode);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_node_q <= mfc_pkg::BcastNode;
      cnt_q      <= '0;
      sum_q      <= '0;
      for (int k = 0; k < mfc_pkg::HdrLen; k++) begin
        hdr_q[k] <= '0;
      end
    end else begin
      if (own_node_we_i) begin
        own_node_q <= own_node_i;
      end
      if (in_fire) begin
        // The final byte closes the frame and clears the count, sum and header for the next one.
        if (s_axis_tlast) begin
          cnt_q <= '0;
          sum_q <= '0;
          for (int k = 0; k < mfc_pkg::HdrLen; k++) begin
            hdr_q[k] <= '0;
          end
        end else begin
          cnt_q <= cnt_d;
          sum_q <= sum_d;
          for (int k = 0; k < mfc_pkg::HdrLen; k++) begin
            hdr_q[k] <= hdr_d[k];
          end
        end
      end
    end
  end

  mfc_skid #(
    .W(mfc_pkg::OutDataW)
  ) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (s_axis_tready),
    .data_i  (verdict),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule
